/* hdl/sine_square_waveform_generator_core_assert.svh */
// Assertion macros shared by the waveform generator RTL.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef SINE_SQUARE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define SINE_SQUARE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSWG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sswg assertion failed");

// The consequent must hold after the antecedent, delayed by dly.
`define SSWG_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("sswg assertion failed");

`endif

/* hdl/sswg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sswg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FREQ_STEP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PHASE_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMPLITUDE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAVE_MODE    = 8'd3;

    localparam int CFG_DATA_W = 32;
    localparam int AMP_W      = 15;
    localparam int SINE_W     = 15;
    localparam int TIME_W     = 32;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_OTHER    = 2'd3
    } t_wave_mode;

    typedef struct packed {
        logic [31:0]      freq_step;
        logic [31:0]      phase_offset;
        logic [AMP_W-1:0] amplitude;
        t_wave_mode       wave_mode;
    } t_cfg;

    // Half pi in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    // Quarter-wave sine entry k of a table with 2^abits steps, unsigned Q0.15.
    // Evaluated at elaboration only, to fill the constant table.
    function automatic logic [SINE_W-1:0] quarter_sine(input longint unsigned k,
                                                      input int unsigned abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        x  = (HALF_PI_Q30 * k) >> abits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + (64'd1 << 14)) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/sswg_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module sswg_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sswg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sswg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sswg_pkg::t_cfg                         o_cfg
);
    import sswg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are refused while reset holds the registers at their defaults.
    assign o_cfg_ready = i_rst_n;

    // Writes to indexes beyond the register list are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_FREQ_STEP:    n_cfg.freq_step    = i_cfg_data;
                CFG_IDX_PHASE_OFFSET: n_cfg.phase_offset = i_cfg_data;
                CFG_IDX_AMPLITUDE:    n_cfg.amplitude    = i_cfg_data[AMP_W-1:0];
                CFG_IDX_WAVE_MODE:    n_cfg.wave_mode    = t_wave_mode'(i_cfg_data[1:0]);
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{freq_step: '0, phase_offset: '0, amplitude: '0,
                       wave_mode: WAVE_SINE};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hdl/sswg_phase.sv */
`timescale 1ns / 1ps
`default_nettype none

module sswg_phase #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic [sswg_pkg::TIME_W-1:0]    i_time_tick,
    input  sswg_pkg::t_cfg                      i_cfg,
    output logic                                o_valid,
    output logic                                o_neg,
    output logic [TABLE_ADDR_BITS:0]            o_addr
);
    import sswg_pkg::*;

    localparam int PROD_W = 2 * TIME_W;
    localparam int ADDR_LSB = PHASE_BITS - 2 - TABLE_ADDR_BITS;
    localparam logic [TABLE_ADDR_BITS:0] QUARTER = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    logic [PROD_W-1:0]          w_prod;
    logic [PHASE_BITS-1:0]      r_prod;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [PHASE_BITS-1:0]      r_phase;
    logic [TABLE_ADDR_BITS-1:0] w_a;
    logic [TABLE_ADDR_BITS:0]   n_addr;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_neg;
    logic [TABLE_ADDR_BITS:0]   r_addr;

    // Stage 1: the product only matters modulo the phase width.
    assign w_prod = PROD_W'(i_time_tick) * PROD_W'(i_cfg.freq_step);

    // Stage 2: add the phase offset.
    assign n_phase = r_prod + PHASE_BITS'(i_cfg.phase_offset);

    // Stage 3: odd quadrants run the table backwards.
    assign w_a    = r_phase[ADDR_LSB +: TABLE_ADDR_BITS];
    assign n_addr = r_phase[PHASE_BITS-2] ? (QUARTER - {1'b0, w_a}) : {1'b0, w_a};

    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod[PHASE_BITS-1:0];
        r_phase <= n_phase;
        r_neg   <= r_phase[PHASE_BITS-1];
        r_addr  <= n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_neg   = r_neg;
    assign o_addr  = r_addr;

endmodule

`default_nettype wire

/* hdl/sswg_sine_rom.sv */
`timescale 1ns / 1ps
`default_nettype none

module sswg_sine_rom #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           i_neg,
    input  wire logic [TABLE_ADDR_BITS:0]       i_addr,
    output logic                                o_valid,
    output logic                                o_neg,
    output logic [sswg_pkg::SINE_W-1:0]         o_mag
);
    import sswg_pkg::*;

    // Quarter wave including both end points.
    localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

    typedef logic [SINE_W-1:0] t_rom [DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < DEPTH; k++) begin
            rom[k] = quarter_sine(longint'(k), TABLE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic              r_valid;
    logic              r_neg;
    logic [SINE_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        r_mag <= SINE_ROM[i_addr];
        r_neg <= i_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;

endmodule

`default_nettype wire

/* hdl/sswg_shape.sv */
`timescale 1ns / 1ps
`default_nettype none

module sswg_shape #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           i_neg,
    input  wire logic [sswg_pkg::SINE_W-1:0]    i_mag,
    input  sswg_pkg::t_cfg                      i_cfg,
    output logic                                o_valid,
    output logic signed [SAMPLE_BITS-1:0]       o_sample
);
    import sswg_pkg::*;

    localparam int PROD_W = AMP_W + SINE_W;
    localparam int MAG_W  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam logic [MAG_W-1:0] LIM = MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [PROD_W:0] ROUND_DOWN = (PROD_W + 1)'((1 << 15) - 1);

    logic                 r_v5;
    logic                 r_v6;
    logic                 r_v7;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_neg5;
    logic                 r_pos5;
    logic                 r_square;
    logic [AMP_W-1:0]     r_amp;
    logic [PROD_W:0]      w_sum;
    logic [AMP_W-1:0]     n_mag;
    logic                 n_sign;
    logic [AMP_W-1:0]     r_mag6;
    logic                 r_sign6;
    logic [MAG_W-1:0]     w_mag_ext;
    logic [MAG_W-1:0]     w_clamped;
    logic [MAG_W-1:0]     w_signed;
    logic [SAMPLE_BITS-1:0] r_sample;

    // Stage 5: amplitude times sine magnitude.
    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(i_cfg.amplitude) * PROD_W'(i_mag);
        r_neg5   <= i_neg;
        r_pos5   <= !i_neg && (i_mag != '0);
        r_square <= (i_cfg.wave_mode == WAVE_SQUARE);
        r_amp    <= i_cfg.amplitude;
    end

    // Stage 6: an arithmetic shift of a negative product rounds away from
    // zero in magnitude, so negative samples add the rounding term first.
    assign w_sum = {1'b0, r_prod} + (r_neg5 ? ROUND_DOWN : '0);

    always_comb begin
        if (r_square) begin
            n_mag  = r_amp;
            n_sign = !r_pos5;
        end else begin
            n_mag  = w_sum[15 +: AMP_W];
            n_sign = r_neg5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag6  <= n_mag;
        r_sign6 <= n_sign;
    end

    // Stage 7: symmetric saturation, then apply the sign.
    assign w_mag_ext = MAG_W'(r_mag6);
    assign w_clamped = (w_mag_ext > LIM) ? LIM : w_mag_ext;
    assign w_signed  = r_sign6 ? (~w_clamped + MAG_W'(1)) : w_clamped;

    always_ff @(posedge i_clk) begin
        r_sample <= w_signed[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign o_valid  = r_v7;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

/* hdl/sine_square_waveform_generator_core.sv */
// Sine and square waveform source. Each accepted command carries a time in
// ticks and produces exactly one sample, at the end of the pipeline, on
// o_sample with o_valid high for one cycle. Once reset is released a new
// command may be issued in every clock cycle, so the block sustains one
// sample per clock; the figure is set by the seven-stage pipeline (multiply,
// phase add, quadrant decode, sine table read, amplitude multiply, rounding,
// saturation), each stage of which handles one word per cycle. busy is high
// only while reset is held; after that the pipeline never stalls, and the
// receiver cannot hold results off, so it must take every sample in the
// cycle it appears. Configuration writes are ready whenever reset is
// released and should only be made while no command is in flight. No
// clearing pass is needed after reset; the sine table is a constant table.
`timescale 1ns / 1ps
`default_nettype none

module sine_square_waveform_generator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Command channel.
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [31:0]                      i_time_tick,
    // Result channel.
    output logic                                  o_valid,
    output logic signed [SAMPLE_BITS-1:0]         o_sample,
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sswg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sswg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sswg_pkg::*;

    `include "sine_square_waveform_generator_core_assert.svh"

    // Cycles from an accepted command to its sample strobe.
    localparam int LATENCY = 7;
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_cfg                     w_cfg;
    logic                     w_accept;
    logic                     w_ph_valid;
    logic                     w_ph_neg;
    logic [TABLE_ADDR_BITS:0] w_ph_addr;
    logic                     w_rom_valid;
    logic                     w_rom_neg;
    logic [SINE_W-1:0]        w_rom_mag;

    // The pipeline takes a word every cycle, so it reports busy only while
    // reset clears the valid bits.
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    sswg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Phase from time times frequency step plus offset, and quadrant folding into a table address.
    sswg_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_time_tick (i_time_tick),
        .i_cfg       (w_cfg),
        .o_valid     (w_ph_valid),
        .o_neg       (w_ph_neg),
        .o_addr      (w_ph_addr)
    );

    // Quarter-wave sine lookup with a registered read.
    sswg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ph_valid),
        .i_neg   (w_ph_neg),
        .i_addr  (w_ph_addr),
        .o_valid (w_rom_valid),
        .o_neg   (w_rom_neg),
        .o_mag   (w_rom_mag)
    );

    // Amplitude scaling, square shaping and saturation.
    sswg_shape #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rom_valid),
        .i_neg    (w_rom_neg),
        .i_mag    (w_rom_mag),
        .i_cfg    (w_cfg),
        .o_valid  (o_valid),
        .o_sample (o_sample)
    );

    // Every accepted word yields its sample after the fixed latency.
    `SSWG_ASSERT_DELAY(a_word_to_sample, i_clk, i_rst_n, w_accept, LATENCY, o_valid)

    // No sample strobe appears without a word accepted at the matching time.
    `SSWG_ASSERT_SAME(a_sample_has_word, i_clk, i_rst_n, o_valid, $past(w_accept, LATENCY))

    // Saturation is symmetric, so the most negative code never leaves the block.
    `SSWG_ASSERT_SAME(a_symmetric_range, i_clk, i_rst_n, o_valid, o_sample != MOST_NEG)

endmodule

`default_nettype wire
